/* src/light_sensor_day_night_detector_unit_macros.svh */
// assertion helpers used by the detector top file
`ifndef LIGHT_SENSOR_DAY_NIGHT_DETECTOR_UNIT_MACROS_SVH
`define LIGHT_SENSOR_DAY_NIGHT_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LSDN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LSDN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lsdn_pkg.sv */
`default_nettype none
package lsdn_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int HISTORY_DEPTH = 5;
   localparam int CFG_BITS = 10;
   localparam int COUNT_BITS = 3;
   localparam int CSR_INDEX_BITS = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_DAY_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NIGHT_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BREAK_COUNT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IR_AUTO_MODE = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODULE_RUNNING = 3'd5;

   // register reset values
   localparam logic [CFG_BITS-1:0] DAY_LIMIT_RESET = 10'd100;
   localparam logic [CFG_BITS-1:0] NIGHT_LIMIT_RESET = 10'd32;
   localparam logic [CFG_BITS-1:0] BREAK_LIMIT_RESET = 10'd100;
   localparam logic [COUNT_BITS-1:0] BREAK_COUNT_RESET = 3'd5;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_DAY = 2'd1,
      ACT_NIGHT = 2'd2
   } lsdn_action_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] day_limit;
      logic [CFG_BITS-1:0] night_limit;
      logic [CFG_BITS-1:0] break_limit;
      logic [COUNT_BITS-1:0] break_count;
      logic ir_auto_mode;
      logic module_running;
   } lsdn_cfg_type;

   typedef struct packed {
      logic is_day;
      logic is_night;
      logic state_changed;
      lsdn_action_type ir_action;
   } lsdn_status_type;

endpackage
`default_nettype wire

/* src/light_sensor_day_night_detector_unit.sv */
// Light sensor day/night detector. Each request carries one converter sample
// and a kind flag on req_tuser (0 normal sample, 1 prime). A normal sample is
// smoothed as (8*sample + h0 + h1 + h2 + h3 + 4*h4)/16 over a five-tap
// history that takes the smoothed value; a run of break_count samples that
// sit at least break_limit away from the reference refills the history with
// the sample first. A prime request fills the history with the raw sample
// and judges it directly. The judge applies day/night hysteresis and, with
// auto mode and running both set, reports an infrared action on a switch.
// One request is taken every clock cycle while the response buffer has room:
// filter, jump counter and judge are a single combinational pass between the
// request and the response buffer. The buffer's two entries keep requests
// flowing while one response waits. The user writes registers through
// csr_we/csr_index/csr_wdata only while idle; the block does not enforce it.
`default_nettype none
`include "light_sensor_day_night_detector_unit_macros.svh"
module light_sensor_day_night_detector_unit
   import lsdn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   // request channel
   input wire logic req_tvalid,
   output logic req_tready,
   // tdata: [SAMPLE_BITS-1:0] sample, zero padded to bytes
   input wire logic [((SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: [0] req_type
   input wire logic req_tuser,
   // response channel
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // tdata: light_value, is_day, is_night, state_changed, ir_action[1:0],
   // zero padded to bytes
   output logic [((SAMPLE_BITS+5+7)/8)*8-1:0] rsp_tdata,
   // configuration write port
   input wire logic csr_we,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input wire logic [CFG_BITS-1:0] csr_wdata
);

   localparam int RSP_TDATA_BITS = ((SAMPLE_BITS + 5 + 7) / 8) * 8;

   lsdn_cfg_type cfg_ff;
   lsdn_status_type status;
   logic [SAMPLE_BITS-1:0] sample;
   logic [SAMPLE_BITS-1:0] value;
   logic [RSP_TDATA_BITS-1:0] rsp_packed;
   logic accept;

   assign sample = req_tdata[SAMPLE_BITS-1:0];
   assign accept = req_tvalid && req_tready;

   // configuration registers, writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.day_limit <= DAY_LIMIT_RESET;
         cfg_ff.night_limit <= NIGHT_LIMIT_RESET;
         cfg_ff.break_limit <= BREAK_LIMIT_RESET;
         cfg_ff.break_count <= BREAK_COUNT_RESET;
         cfg_ff.ir_auto_mode <= 1'b0;
         cfg_ff.module_running <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_DAY_LIMIT: cfg_ff.day_limit <= csr_wdata;
            REG_NIGHT_LIMIT: cfg_ff.night_limit <= csr_wdata;
            REG_BREAK_LIMIT: cfg_ff.break_limit <= csr_wdata;
            REG_BREAK_COUNT: cfg_ff.break_count <= csr_wdata[COUNT_BITS-1:0];
            REG_IR_AUTO_MODE: cfg_ff.ir_auto_mode <= csr_wdata[0];
            REG_MODULE_RUNNING: cfg_ff.module_running <= csr_wdata[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // smoothing filter, history and jump detector
   lsdn_filter #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_filter (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .prime(req_tuser),
      .sample(sample),
      .cfg(cfg_ff),
      .value(value)
   );

   // hysteresis judge on the filtered or raw value
   lsdn_judge #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_judge (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .value(value),
      .cfg(cfg_ff),
      .status(status)
   );

   // response fields packed from the lowest bit up
   assign rsp_packed = RSP_TDATA_BITS'({status.ir_action, status.state_changed,
                                        status.is_night, status.is_day, value});

   // response buffer decouples the two sides
   lsdn_outbuf #(
      .WIDTH(RSP_TDATA_BITS)
   ) u_outbuf (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_data(rsp_packed),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(rsp_tdata)
   );

   // a switch always leaves exactly one of day and night set
   `LSDN_ASSERT_NOW(a_switch_exclusive, accept && status.state_changed, status.is_day != status.is_night, "switch left day and night equal")

   // an infrared action needs auto mode, running and a switch
   `LSDN_ASSERT_NOW(a_action_armed, accept && (status.ir_action != ACT_NONE), cfg_ff.ir_auto_mode && cfg_ff.module_running && status.state_changed, "infrared action without arming or switch")

   // a stalled request side means responses are waiting
   `LSDN_ASSERT_NOW(a_stall_has_data, !req_tready, rsp_tvalid, "request stalled with empty buffer")

   // after an accepted request the response side is valid in the next cycle
   `LSDN_ASSERT_NEXT(a_accept_shows, accept, rsp_tvalid, "accepted request produced no response")

endmodule
`default_nettype wire

/* src/lsdn_filter.sv */
`default_nettype none
module lsdn_filter
   import lsdn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire logic prime,
   input wire logic [SAMPLE_BITS-1:0] sample,
   input wire lsdn_cfg_type cfg,
   output logic [SAMPLE_BITS-1:0] value
);

   localparam int CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
   localparam int SUM_BITS = SAMPLE_BITS + 4;

   logic [SAMPLE_BITS-1:0] history_ff [HISTORY_DEPTH];
   logic [SAMPLE_BITS-1:0] history_in [HISTORY_DEPTH];
   logic [SAMPLE_BITS-1:0] reference_ff, reference_in;
   logic [COUNT_BITS-1:0] jump_count_ff, jump_count_in;

   logic [SAMPLE_BITS-1:0] diff;
   logic [COUNT_BITS-1:0] count_inc;
   logic jump, refill;
   logic [SAMPLE_BITS-1:0] taps [HISTORY_DEPTH];
   logic [SUM_BITS-1:0] sum;

   always_comb begin
      diff = (sample > reference_ff) ? (sample - reference_ff) : (reference_ff - sample);
      jump = CMP_BITS'(diff) >= CMP_BITS'(cfg.break_limit);
      count_inc = jump_count_ff + COUNT_BITS'(1);
      refill = jump && (count_inc == cfg.break_count);
      if (!jump || refill) begin
         jump_count_in = '0;
      end else begin
         jump_count_in = count_inc;
      end

      // weights: 8 on the sample, 1 on older taps, 4 on the newest tap
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         taps[i] = refill ? sample : history_ff[i];
      end
      sum = SUM_BITS'(sample) << 3;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         sum = sum + SUM_BITS'(taps[i]);
      end
      sum = sum + (SUM_BITS'(taps[HISTORY_DEPTH-1]) << 2);

      if (prime) begin
         value = sample;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_in[i] = sample;
         end
         reference_in = reference_ff;
      end else begin
         value = sum[SUM_BITS-1:4];
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            history_in[i] = taps[i+1];
         end
         history_in[HISTORY_DEPTH-1] = value;
         reference_in = (jump_count_in == '0) ? value : reference_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
         reference_ff <= '0;
         jump_count_ff <= '0;
      end else if (accept) begin
         history_ff <= history_in;
         reference_ff <= reference_in;
         if (!prime) begin
            jump_count_ff <= jump_count_in;
         end
      end
   end

endmodule
`default_nettype wire

/* src/lsdn_judge.sv */
`default_nettype none
module lsdn_judge
   import lsdn_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire logic [SAMPLE_BITS-1:0] value,
   input wire lsdn_cfg_type cfg,
   output lsdn_status_type status
);

   localparam int CMP_BITS = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

   logic day_ff, night_ff;
   logic armed;

   always_comb begin
      armed = cfg.ir_auto_mode && cfg.module_running;
      status.is_day = day_ff;
      status.is_night = night_ff;
      status.state_changed = 1'b0;
      status.ir_action = ACT_NONE;
      if (CMP_BITS'(value) > CMP_BITS'(cfg.day_limit)) begin
         if (night_ff) begin
            status.is_day = 1'b1;
            status.is_night = 1'b0;
            status.state_changed = 1'b1;
            status.ir_action = armed ? ACT_DAY : ACT_NONE;
         end
      end else if (CMP_BITS'(value) < CMP_BITS'(cfg.night_limit)) begin
         if (day_ff) begin
            status.is_day = 1'b0;
            status.is_night = 1'b1;
            status.state_changed = 1'b1;
            status.ir_action = armed ? ACT_NIGHT : ACT_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff <= 1'b1;
         night_ff <= 1'b1;
      end else if (accept) begin
         day_ff <= status.is_day;
         night_ff <= status.is_night;
      end
   end

endmodule
`default_nettype wire

/* src/lsdn_outbuf.sv */
`default_nettype none
module lsdn_outbuf
   import lsdn_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire logic [WIDTH-1:0] in_data,
   output logic out_valid,
   input wire logic out_ready,
   output logic [WIDTH-1:0] out_data
);

   // two-entry skid buffer: head slot feeds the output
   logic [WIDTH-1:0] head_ff, tail_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data = head_ff;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10: count_ff <= count_ff + 2'd1;
            2'b01: count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_ff <= in_data;
            end else begin
               tail_ff <= in_data;
            end
         end
         2'b01: begin
            head_ff <= tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_ff <= in_data;
            end else begin
               head_ff <= tail_ff;
               tail_ff <= in_data;
            end
         end
         default: begin
            head_ff <= head_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lsdn_pkg::*;

   localparam int SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 5 + 7) / 8) * 8;
   localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

   // request kinds carried on req_tuser
   localparam logic KIND_NORMAL = 1'b0;
   localparam logic KIND_PRIME = 1'b1;

   localparam int NUM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic kind;
      logic [SAMPLE_BITS-1:0] sample;
   } light_request_type;

   typedef struct {
      logic [SAMPLE_BITS-1:0] light_value;
      logic is_day;
      logic is_night;
      logic state_changed;
      lsdn_action_type ir_action;
   } light_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_tvalid = 1'b0;
   logic req_tready;
   // tdata: [SAMPLE_BITS-1:0] sample, zero padded
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   // tuser: [0] req_type
   logic req_tuser = KIND_NORMAL;

   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // tdata: light_value, is_day, is_night, state_changed, ir_action[1:0], zero padded
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_DAY_LIMIT;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   light_sensor_day_night_detector_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // requests waiting to be offered, and readings waiting to come back
   light_request_type pending_samples[$];
   light_reading_type expected_readings[$];
   light_request_type in_flight;

   // idle rates in percent, set per phase
   int send_idle_pct = 17;
   int recv_idle_pct = 56;

   // long receiver hold-off, counted in its own process
   logic hold_armed = 1'b0;
   int hold_count = 0;

   int mismatches = 0;

   // shadow of the detector: configuration, filter history and judge state
   lsdn_cfg_type cfg_shadow;
   logic [SAMPLE_BITS-1:0] history_taps[HISTORY_DEPTH];
   logic [SAMPLE_BITS-1:0] ref_level;
   logic [COUNT_BITS-1:0] jump_run;
   logic day_flag;
   logic night_flag;

   // one request through filter, jump counter and day/night judge
   function automatic light_reading_type smooth_and_judge(logic kind,
                                                          logic [SAMPLE_BITS-1:0] s);
      light_reading_type r;
      logic [SAMPLE_BITS-1:0] diff;
      logic [SAMPLE_BITS-1:0] v;
      int sum;
      logic armed;
      if (kind == KIND_PRIME) begin
         // prime: fill history, judge the raw sample, leave reference and count alone
         for (int i = 0; i < HISTORY_DEPTH; i++) history_taps[i] = s;
         v = s;
      end else begin
         diff = (s > ref_level) ? s - ref_level : ref_level - s;
         if (diff >= cfg_shadow.break_limit) begin
            // 3-bit counter wraps, so a zero break_count matches on the eighth jump
            jump_run = jump_run + COUNT_BITS'(1);
            if (jump_run == cfg_shadow.break_count) begin
               for (int i = 0; i < HISTORY_DEPTH; i++) history_taps[i] = s;
               jump_run = '0;
            end
         end else begin
            jump_run = '0;
         end
         sum = 8 * int'(s) + int'(history_taps[0]) + int'(history_taps[1])
               + int'(history_taps[2]) + int'(history_taps[3]) + 4 * int'(history_taps[4]);
         v = SAMPLE_BITS'(sum >> 4);
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) history_taps[i] = history_taps[i + 1];
         history_taps[HISTORY_DEPTH - 1] = v;
         // reference follows the smoothed value only outside a jump run
         if (jump_run == '0) ref_level = v;
      end

      armed = cfg_shadow.ir_auto_mode && cfg_shadow.module_running;
      r.state_changed = 1'b0;
      r.ir_action = ACT_NONE;
      // hysteresis; both flags set after reset so either side switches first
      if (v > cfg_shadow.day_limit) begin
         if (night_flag) begin
            night_flag = 1'b0;
            day_flag = 1'b1;
            r.state_changed = 1'b1;
            if (armed) r.ir_action = ACT_DAY;
         end
      end else if (v < cfg_shadow.night_limit) begin
         if (day_flag) begin
            day_flag = 1'b0;
            night_flag = 1'b1;
            r.state_changed = 1'b1;
            if (armed) r.ir_action = ACT_NIGHT;
         end
      end
      r.light_value = v;
      r.is_day = day_flag;
      r.is_night = night_flag;
      return r;
   endfunction

   // driver: keeps a request up until it is taken, then pulls the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(smooth_and_judge(in_flight.kind, in_flight.sample));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_BITS'(in_flight.sample);
               req_tuser <= in_flight.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // hold-off counter for the long receiver stall
   always @(posedge clock) begin
      if (hold_armed && hold_count < LONG_HOLD_CYCLES) hold_count <= hold_count + 1;
   end

   task automatic check_field(string name, logic [SAMPLE_BITS-1:0] exp_v,
                              logic [SAMPLE_BITS-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // monitor: compares each taken reading with the oldest expectation
   always @(posedge clock) begin
      light_reading_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $error("reading with no request outstanding: tdata %0h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               check_field("light_value", want.light_value, rsp_tdata[SAMPLE_BITS-1:0]);
               check_field("is_day", SAMPLE_BITS'(want.is_day),
                           SAMPLE_BITS'(rsp_tdata[SAMPLE_BITS]));
               check_field("is_night", SAMPLE_BITS'(want.is_night),
                           SAMPLE_BITS'(rsp_tdata[SAMPLE_BITS+1]));
               check_field("state_changed", SAMPLE_BITS'(want.state_changed),
                           SAMPLE_BITS'(rsp_tdata[SAMPLE_BITS+2]));
               check_field("ir_action", SAMPLE_BITS'(want.ir_action),
                           SAMPLE_BITS'(rsp_tdata[SAMPLE_BITS+4:SAMPLE_BITS+3]));
            end
         end
         if (hold_armed && hold_count < LONG_HOLD_CYCLES) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic offer(logic kind, int value);
      light_request_type item;
      item.kind = kind;
      item.sample = SAMPLE_BITS'(value);
      pending_samples.push_back(item);
   endtask

   // register write while idle; shadow copy follows the write
   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_BITS'(value);
      case (idx)
         REG_DAY_LIMIT: cfg_shadow.day_limit = CFG_BITS'(value);
         REG_NIGHT_LIMIT: cfg_shadow.night_limit = CFG_BITS'(value);
         REG_BREAK_LIMIT: cfg_shadow.break_limit = CFG_BITS'(value);
         REG_BREAK_COUNT: cfg_shadow.break_count = COUNT_BITS'(value);
         REG_IR_AUTO_MODE: cfg_shadow.ir_auto_mode = value[0];
         REG_MODULE_RUNNING: cfg_shadow.module_running = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // sender pause until every outstanding reading is back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_readings.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   // plateaus with small jitter, sudden level jumps that hold, isolated noise, primes
   task automatic queue_scene(int count);
      int level;
      int spread;
      int roll;
      int value;
      level = $urandom_range(SAMPLE_MAX);
      spread = $urandom_range(24);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            case ($urandom_range(2))
               0: level = $urandom_range(40);
               1: level = $urandom_range(SAMPLE_MAX, SAMPLE_MAX - 43);
               default: level = $urandom_range(SAMPLE_MAX);
            endcase
            spread = $urandom_range(24);
         end
         if (roll >= 8 && roll < 14) begin
            value = $urandom_range(SAMPLE_MAX);
         end else begin
            value = level + int'($urandom_range(2 * spread)) - spread;
            if (value < 0) value = 0;
            if (value > SAMPLE_MAX) value = SAMPLE_MAX;
         end
         offer((roll >= 94) ? KIND_PRIME : KIND_NORMAL, value);
      end
   endtask

   task automatic configure_phase(int p);
      int night_v;
      int day_v;
      int break_v;
      case (p)
         // limits that can never be crossed
         0: begin
            day_v = SAMPLE_MAX;
            night_v = 0;
            break_v = SAMPLE_MAX;
         end
         // every value lies past one limit, break limit zero makes every sample a jump
         1: begin
            day_v = 0;
            night_v = SAMPLE_MAX;
            break_v = 0;
         end
         default: begin
            if (p % 5 == 4) begin
               night_v = $urandom_range(SAMPLE_MAX);
               day_v = $urandom_range(SAMPLE_MAX);
            end else begin
               night_v = $urandom_range(400);
               day_v = night_v + $urandom_range(500);
            end
            break_v = $urandom_range(300);
         end
      endcase
      write_reg(REG_DAY_LIMIT, day_v);
      write_reg(REG_NIGHT_LIMIT, night_v);
      write_reg(REG_BREAK_LIMIT, break_v);
      write_reg(REG_BREAK_COUNT, (p == 0) ? 7 : (p == 1) ? 1 : int'($urandom_range(7)));
      write_reg(REG_IR_AUTO_MODE, int'($urandom_range(3) != 0));
      write_reg(REG_MODULE_RUNNING, int'($urandom_range(3) != 0));
   endtask

   initial begin
      cfg_shadow.day_limit = DAY_LIMIT_RESET;
      cfg_shadow.night_limit = NIGHT_LIMIT_RESET;
      cfg_shadow.break_limit = BREAK_LIMIT_RESET;
      cfg_shadow.break_count = BREAK_COUNT_RESET;
      cfg_shadow.ir_auto_mode = 1'b0;
      cfg_shadow.module_running = 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) history_taps[i] = '0;
      ref_level = '0;
      jump_run = '0;
      day_flag = 1'b1;
      night_flag = 1'b1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: first dark sample switches to night, prime to day,
      // then a run of bright jumps refills the history
      offer(KIND_NORMAL, 0);
      offer(KIND_PRIME, SAMPLE_MAX);
      repeat (5) offer(KIND_NORMAL, SAMPLE_MAX);
      offer(KIND_NORMAL, 0);
      wait_drained();

      // overlapping limits, infrared armed, zero break count
      write_reg(REG_IR_AUTO_MODE, 1);
      write_reg(REG_MODULE_RUNNING, 1);
      write_reg(REG_DAY_LIMIT, 0);
      write_reg(REG_NIGHT_LIMIT, SAMPLE_MAX);
      write_reg(REG_BREAK_LIMIT, SAMPLE_MAX);
      write_reg(REG_BREAK_COUNT, 0);
      offer(KIND_PRIME, 0);
      offer(KIND_PRIME, SAMPLE_MAX);
      offer(KIND_PRIME, 0);
      offer(KIND_NORMAL, 0);
      // eight full-scale samples: none is a jump, so the counter clears and no refill happens
      repeat (8) offer(KIND_NORMAL, SAMPLE_MAX);
      wait_drained();

      // dark samples with break_count 7, then more after break_count drops to 2
      write_reg(REG_BREAK_COUNT, 7);
      repeat (3) offer(KIND_NORMAL, 0);
      wait_drained();
      write_reg(REG_BREAK_COUNT, 2);
      repeat (4) offer(KIND_NORMAL, 0);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 4) begin
            send_idle_pct = 17;
            recv_idle_pct = 56;
         end else if (p < 8) begin
            send_idle_pct = 56;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure_phase(p);
         // receiver stalls for a long stretch while requests keep being offered
         if (p == 2) hold_armed = 1'b1;
         queue_scene(ITEMS_PER_PHASE);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("light_sensor_day_night_detector_unit test passed");
      end else begin
         $display("light_sensor_day_night_detector_unit test failed");
      end
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #5000000;
      $display("light_sensor_day_night_detector_unit test failed");
      $finish;
   end

endmodule

/* light_sensor_day_night_detector_unit.f */
+incdir+src
src/lsdn_pkg.sv
src/lsdn_filter.sv
src/lsdn_judge.sv
src/lsdn_outbuf.sv
src/light_sensor_day_night_detector_unit.sv
tb/sv/testbench.sv
